// ===== hw/rtl/dwvd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package dwvd_pkg;

  localparam int unsigned CAPACITY_DEF = 64;
  localparam int unsigned DATA_W       = 32;
  localparam int unsigned ACT_W        = 3;
  localparam int unsigned STAT_W       = 2;
  localparam int unsigned OCC_W        = 7;

  // Command codes carried in the request
  typedef enum logic [ACT_W-1:0] {
    ACT_PUSH_FRONT = 3'd0,
    ACT_PUSH_BACK  = 3'd1,
    ACT_POP_FRONT  = 3'd2,
    ACT_POP_BACK   = 3'd3,
    ACT_DELETE     = 3'd4,
    ACT_CLEAR      = 3'd5,
    ACT_READ_FIRST = 3'd6,
    ACT_READ_LAST  = 3'd7
  } action_e;

  // Result status codes
  typedef enum logic [STAT_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2
  } status_e;

  // One result on its way from the sequencer to the output register
  typedef struct packed {
    logic                     valid;
    logic signed [DATA_W-1:0] data;
    status_e                  status;
    logic [OCC_W-1:0]         occupancy;
    logic                     last_of_run;
  } res_t;

endpackage

`default_nettype wire

// ===== hw/rtl/dwvd_req_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface dwvd_req_if;
  logic                               valid;
  logic                               ready;
  logic [dwvd_pkg::ACT_W-1:0]         action;
  logic signed [dwvd_pkg::DATA_W-1:0] operand;

  modport source (output valid, output action, output operand, input ready);
  modport sink   (input valid, input action, input operand, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/dwvd_res_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface dwvd_res_if;
  logic                               valid;
  logic                               ready;
  logic signed [dwvd_pkg::DATA_W-1:0] data;
  logic [dwvd_pkg::STAT_W-1:0]        status;
  logic [dwvd_pkg::OCC_W-1:0]         occupancy;
  logic                               last_of_run;

  modport source (output valid, output data, output status, output occupancy,
                  output last_of_run, input ready);
  modport sink   (input valid, input data, input status, input occupancy,
                  input last_of_run, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/dwvd_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module dwvd_ram #(
  parameter int unsigned CAPACITY = dwvd_pkg::CAPACITY_DEF,
  localparam int unsigned AW      = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
  input  wire logic                               clk_i,
  input  wire logic                               we_i,
  input  wire logic                               re_i,
  input  wire logic [AW-1:0]                      addr_i,
  input  wire logic signed [dwvd_pkg::DATA_W-1:0] wdata_i,
  output logic signed [dwvd_pkg::DATA_W-1:0]      rdata_o
);

  logic signed [dwvd_pkg::DATA_W-1:0] mem_q [CAPACITY];
  logic signed [dwvd_pkg::DATA_W-1:0] rdata_q;

  // Write and registered read on one port; read data holds while idle
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== hw/rtl/dwvd_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module dwvd_ctrl #(
  parameter int unsigned CAPACITY = dwvd_pkg::CAPACITY_DEF,
  localparam int unsigned AW      = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
  localparam int unsigned CW      = $clog2(CAPACITY + 1)
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               req_valid_i,
  output logic                                    req_ready_o,
  input  wire logic [dwvd_pkg::ACT_W-1:0]         req_action_i,
  input  wire logic signed [dwvd_pkg::DATA_W-1:0] req_operand_i,
  input  wire logic                               res_ready_i,
  output dwvd_pkg::res_t                          res_o,
  output logic                                    mem_we_o,
  output logic                                    mem_re_o,
  output logic [AW-1:0]                           mem_addr_o,
  output logic signed [dwvd_pkg::DATA_W-1:0]      mem_wdata_o,
  input  wire logic signed [dwvd_pkg::DATA_W-1:0] mem_rdata_i
);

  typedef enum logic [6:0] {
    S_IDLE     = 7'b0000001,
    S_POP      = 7'b0000010,
    S_DEL_RD   = 7'b0000100,
    S_DEL_WR   = 7'b0001000,
    S_DEL_DONE = 7'b0010000,
    S_RD_RD    = 7'b0100000,
    S_RD_OUT   = 7'b1000000
  } state_e;

  localparam logic [AW:0]   CAP_SUM  = (AW + 1)'(CAPACITY);
  localparam logic [AW-1:0] CAP_LAST = AW'(CAPACITY - 1);
  localparam logic [CW-1:0] CAP_CNT  = CW'(CAPACITY);

  state_e                             state_q, state_d;
  logic [AW-1:0]                      head_q, head_d;
  logic [CW-1:0]                      count_q, count_d;
  logic signed [dwvd_pkg::DATA_W-1:0] op_q, op_d;
  logic [CW-1:0]                      idx_q, idx_d;
  logic [CW-1:0]                      kept_q, kept_d;
  logic [CW-1:0]                      end_q, end_d;

  logic [AW-1:0] off;
  logic [AW:0]   sum;
  logic [AW-1:0] addr;
  logic [AW-1:0] head_inc;
  logic          full;
  logic          empty;
  logic          accept;
  logic [CW-1:0] rd_len;
  logic [CW-1:0] rd_start;

  // Shared ring address unit: head plus offset, wrapped at the capacity
  assign sum  = {1'b0, head_q} + {1'b0, off};
  assign addr = (sum >= CAP_SUM) ? AW'(sum - CAP_SUM) : AW'(sum);

  assign head_inc = (head_q == CAP_LAST) ? '0 : head_q + AW'(1);
  assign full     = (count_q == CAP_CNT);
  assign empty    = (count_q == '0);

  assign req_ready_o = (state_q == S_IDLE) && res_ready_i;
  assign accept      = req_valid_i && req_ready_o;

  // Clip the read length to the count and pick the first entry to stream
  assign rd_len   = ($unsigned(req_operand_i) > 32'(count_q)) ? count_q
                                                               : req_operand_i[CW-1:0];
  assign rd_start = (dwvd_pkg::action_e'(req_action_i) == dwvd_pkg::ACT_READ_FIRST)
                    ? '0 : count_q - rd_len;

  assign mem_addr_o = addr;

  // Sequence each command through the ring address unit and the memory
  always_comb begin
    state_d     = state_q;
    head_d      = head_q;
    count_d     = count_q;
    op_d        = op_q;
    idx_d       = idx_q;
    kept_d      = kept_q;
    end_d       = end_q;
    off         = '0;
    mem_we_o    = 1'b0;
    mem_re_o    = 1'b0;
    mem_wdata_o = req_operand_i;
    res_o       = '0;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          case (dwvd_pkg::action_e'(req_action_i))
            dwvd_pkg::ACT_PUSH_FRONT, dwvd_pkg::ACT_PUSH_BACK: begin
              res_o.valid       = 1'b1;
              res_o.last_of_run = 1'b1;
              if (full) begin
                res_o.status    = dwvd_pkg::STAT_FULL;
                res_o.occupancy = dwvd_pkg::OCC_W'(count_q);
              end else begin
                off      = (dwvd_pkg::action_e'(req_action_i) == dwvd_pkg::ACT_PUSH_FRONT)
                           ? CAP_LAST : count_q[AW-1:0];
                mem_we_o = 1'b1;
                if (dwvd_pkg::action_e'(req_action_i) == dwvd_pkg::ACT_PUSH_FRONT) begin
                  head_d = addr;
                end
                count_d         = count_q + CW'(1);
                res_o.status    = dwvd_pkg::STAT_OK;
                res_o.occupancy = dwvd_pkg::OCC_W'(count_q + CW'(1));
              end
            end
            dwvd_pkg::ACT_POP_FRONT, dwvd_pkg::ACT_POP_BACK: begin
              if (empty) begin
                res_o.valid       = 1'b1;
                res_o.last_of_run = 1'b1;
                res_o.status      = dwvd_pkg::STAT_EMPTY;
              end else begin
                mem_re_o = 1'b1;
                count_d  = count_q - CW'(1);
                if (dwvd_pkg::action_e'(req_action_i) == dwvd_pkg::ACT_POP_FRONT) begin
                  off    = '0;
                  head_d = head_inc;
                end else begin
                  off = AW'(count_q - CW'(1));
                end
                state_d = S_POP;
              end
            end
            dwvd_pkg::ACT_DELETE: begin
              if (empty) begin
                res_o.valid       = 1'b1;
                res_o.last_of_run = 1'b1;
                res_o.status      = dwvd_pkg::STAT_OK;
              end else begin
                op_d    = req_operand_i;
                idx_d   = '0;
                kept_d  = '0;
                state_d = S_DEL_RD;
              end
            end
            dwvd_pkg::ACT_CLEAR: begin
              count_d           = '0;
              head_d            = '0;
              res_o.valid       = 1'b1;
              res_o.last_of_run = 1'b1;
              res_o.status      = dwvd_pkg::STAT_OK;
            end
            default: begin
              // Reads of the first or last n entries
              if (empty) begin
                res_o.valid       = 1'b1;
                res_o.last_of_run = 1'b1;
                res_o.status      = dwvd_pkg::STAT_EMPTY;
              end else if (!req_operand_i[dwvd_pkg::DATA_W-1] && (req_operand_i != '0)) begin
                idx_d   = rd_start;
                end_d   = rd_start + rd_len - CW'(1);
                state_d = S_RD_RD;
              end
            end
          endcase
        end
      end
      S_POP: begin
        res_o.valid       = 1'b1;
        res_o.data        = mem_rdata_i;
        res_o.status      = dwvd_pkg::STAT_OK;
        res_o.occupancy   = dwvd_pkg::OCC_W'(count_q);
        res_o.last_of_run = 1'b1;
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end
      S_DEL_RD: begin
        off      = idx_q[AW-1:0];
        mem_re_o = 1'b1;
        state_d  = S_DEL_WR;
      end
      S_DEL_WR: begin
        // Keep entries that differ, packed toward the head
        off         = kept_q[AW-1:0];
        mem_wdata_o = mem_rdata_i;
        if (mem_rdata_i != op_q) begin
          mem_we_o = 1'b1;
          kept_d   = kept_q + CW'(1);
        end
        idx_d   = idx_q + CW'(1);
        state_d = (idx_q + CW'(1) == count_q) ? S_DEL_DONE : S_DEL_RD;
      end
      S_DEL_DONE: begin
        res_o.valid       = 1'b1;
        res_o.status      = dwvd_pkg::STAT_OK;
        res_o.occupancy   = dwvd_pkg::OCC_W'(kept_q);
        res_o.last_of_run = 1'b1;
        if (res_ready_i) begin
          count_d = kept_q;
          state_d = S_IDLE;
        end
      end
      S_RD_RD: begin
        off      = idx_q[AW-1:0];
        mem_re_o = 1'b1;
        state_d  = S_RD_OUT;
      end
      S_RD_OUT: begin
        res_o.valid       = 1'b1;
        res_o.data        = mem_rdata_i;
        res_o.status      = dwvd_pkg::STAT_OK;
        res_o.occupancy   = dwvd_pkg::OCC_W'(count_q);
        res_o.last_of_run = (idx_q == end_q);
        if (res_ready_i) begin
          if (idx_q == end_q) begin
            state_d = S_IDLE;
          end else begin
            idx_d   = idx_q + CW'(1);
            state_d = S_RD_RD;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Hold sequencer and queue control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      head_q  <= '0;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      count_q <= count_d;
    end
  end

  // Hold the walk counters and the delete value
  always_ff @(posedge clk_i) begin
    op_q   <= op_d;
    idx_q  <= idx_d;
    kept_q <= kept_d;
    end_q  <= end_d;
  end

endmodule

`default_nettype wire

// ===== hw/rtl/deque_with_value_delete.sv =====
// Bounded double-ended queue of signed 32-bit values kept as a ring in memory.
// Requests arrive on req_i (action, operand); results leave on res_o
// (data, status, occupancy, last_of_run), both valid/ready channels.
// Push and clear requests, and any request turned away as full or empty,
// give one result, captured by the output register as the request is accepted.
// A pop gives its result after one memory read.
// A delete walks the live entries one at a time (read, then compare and write
// back) and gives one result once the walk is done.
// A read of n entries streams them front to back, last_of_run on the final one;
// on a non-empty queue, n zero or negative gives no result.
// The block takes one request at a time: req_i.ready stays low until every
// result of the current request has entered the output register.
// A stalled receiver holds the output register; the sequencer waits on its
// next result, while a delete walk keeps running until its result is due.
// Reset empties the queue and sets the head to slot 0; the memory itself is
// not cleared and needs no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module deque_with_value_delete #(
  parameter int unsigned CAPACITY = dwvd_pkg::CAPACITY_DEF,
  localparam int unsigned AW      = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
  input wire logic   clk_i,
  input wire logic   rst_ni,
  dwvd_req_if.sink   req_i,
  dwvd_res_if.source res_o
);

  dwvd_pkg::res_t                     res;
  dwvd_pkg::res_t                     out_q;
  logic                               out_valid_q;
  logic                               res_ready;
  logic                               mem_we;
  logic                               mem_re;
  logic [AW-1:0]                      mem_addr;
  logic signed [dwvd_pkg::DATA_W-1:0] mem_wdata;
  logic signed [dwvd_pkg::DATA_W-1:0] mem_rdata;

  dwvd_ctrl #(
    .CAPACITY (CAPACITY)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .req_valid_i   (req_i.valid),
    .req_ready_o   (req_i.ready),
    .req_action_i  (req_i.action),
    .req_operand_i (req_i.operand),
    .res_ready_i   (res_ready),
    .res_o         (res),
    .mem_we_o      (mem_we),
    .mem_re_o      (mem_re),
    .mem_addr_o    (mem_addr),
    .mem_wdata_o   (mem_wdata),
    .mem_rdata_i   (mem_rdata)
  );

  dwvd_ram #(
    .CAPACITY (CAPACITY)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .re_i    (mem_re),
    .addr_i  (mem_addr),
    .wdata_i (mem_wdata),
    .rdata_o (mem_rdata)
  );

  // Output register: free when empty or being drained this cycle
  assign res_ready = !out_valid_q || res_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res.valid;
    end
  end

  // Capture the result payload
  always_ff @(posedge clk_i) begin
    if (res_ready && res.valid) begin
      out_q <= res;
    end
  end

  assign res_o.valid       = out_valid_q;
  assign res_o.data        = out_q.data;
  assign res_o.status      = out_q.status;
  assign res_o.occupancy   = out_q.occupancy;
  assign res_o.last_of_run = out_q.last_of_run;

  // Occupancy never exceeds the capacity
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid |-> (res_o.occupancy <= dwvd_pkg::OCC_W'(CAPACITY)))
    else $error("occupancy above capacity");

  // A dropped push only happens on a full queue
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && (res_o.status == dwvd_pkg::STAT_FULL))
      |-> (res_o.occupancy == dwvd_pkg::OCC_W'(CAPACITY)))
    else $error("full status with room left");

  // An empty report only happens on an empty queue
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && (res_o.status == dwvd_pkg::STAT_EMPTY))
      |-> (res_o.occupancy == '0))
    else $error("empty status with entries held");

  // A request is taken only when the output register can take its result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.valid && req_i.ready) |-> (!out_valid_q || res_o.ready))
    else $error("request accepted while output stalled");

endmodule

`default_nettype wire

// ===== tb/deque_with_value_delete_chk.sv =====
`timescale 1ns / 1ps

module deque_with_value_delete_chk
  import dwvd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  dwvd_req_if         req_i,
  dwvd_res_if         res_i,
  output int unsigned mismatches_o,
  output int unsigned pending_o
);

  localparam int unsigned CAP = CAPACITY_DEF;
  localparam int unsigned AW  = $clog2(CAP);

  typedef struct packed {
    logic signed [DATA_W-1:0] data;
    status_e                  status;
    logic [OCC_W-1:0]         occupancy;
    logic                     last;
  } outcome_t;

  // Shadow deque: ring storage, front slot and fill level
  logic [DATA_W-1:0] ring_q [CAP];
  logic [AW-1:0]     head_q;
  logic [OCC_W-1:0]  count_q;
  outcome_t          deque_outcomes_q [$];
  int unsigned       errors;

  function automatic logic [AW-1:0] ring_slot(input int unsigned off);
    return head_q + AW'(off);
  endfunction

  // Queue one result tagged with the fill level after the request
  task automatic add_outcome(input logic [DATA_W-1:0] value, input status_e st,
                             input logic last);
    outcome_t o;
    o.data      = value;
    o.status    = st;
    o.occupancy = count_q;
    o.last      = last;
    deque_outcomes_q.push_back(o);
  endtask

  // Apply one request to the shadow deque and queue the results it causes
  task automatic run_deque_op(input action_e act, input logic signed [DATA_W-1:0] opnd);
    int unsigned       kept;
    int unsigned       m;
    int unsigned       start;
    int unsigned       i;
    int                n;
    logic [DATA_W-1:0] v;
    case (act)
      ACT_PUSH_FRONT, ACT_PUSH_BACK: begin
        if (count_q >= CAP) begin
          add_outcome('0, STAT_FULL, 1'b1);
        end else begin
          if (act == ACT_PUSH_FRONT) begin
            head_q = head_q - 1'b1;
            ring_q[head_q] = opnd;
          end else begin
            ring_q[ring_slot(count_q)] = opnd;
          end
          count_q = count_q + 1'b1;
          add_outcome('0, STAT_OK, 1'b1);
        end
      end
      ACT_POP_FRONT, ACT_POP_BACK: begin
        if (count_q == 0) begin
          add_outcome('0, STAT_EMPTY, 1'b1);
        end else begin
          if (act == ACT_POP_FRONT) begin
            v = ring_q[head_q];
            head_q = head_q + 1'b1;
          end else begin
            v = ring_q[ring_slot(count_q - 1)];
          end
          count_q = count_q - 1'b1;
          add_outcome(v, STAT_OK, 1'b1);
        end
      end
      ACT_DELETE: begin
        // Pack survivors toward the head, keeping their order
        kept = 0;
        for (i = 0; i < count_q; i++) begin
          v = ring_q[ring_slot(i)];
          if (v != opnd) begin
            ring_q[ring_slot(kept)] = v;
            kept++;
          end
        end
        count_q = kept;
        add_outcome('0, STAT_OK, 1'b1);
      end
      ACT_CLEAR: begin
        count_q = '0;
        head_q  = '0;
        add_outcome('0, STAT_OK, 1'b1);
      end
      default: begin
        // Read first n or last n, streamed front to back
        n = opnd;
        if (count_q == 0) begin
          add_outcome('0, STAT_EMPTY, 1'b1);
        end else if (n > 0) begin
          m = (n < int'(count_q)) ? n : count_q;
          start = (act == ACT_READ_FIRST) ? 0 : count_q - m;
          for (i = 0; i < m; i++) begin
            add_outcome(ring_q[ring_slot(start + i)], STAT_OK, (i + 1) == m);
          end
        end
      end
    endcase
  endtask

  // Compare one accepted result with the oldest outstanding one
  task automatic check_result();
    outcome_t want;
    outcome_t got;
    got.data      = res_i.data;
    got.status    = status_e'(res_i.status);
    got.occupancy = res_i.occupancy;
    got.last      = res_i.last_of_run;
    if (deque_outcomes_q.size() == 0) begin
      errors++;
      if (errors <= 10) begin
        $display("%0t: unexpected result: data %0d status %0d occupancy %0d last %0b",
                 $realtime, got.data, got.status, got.occupancy, got.last);
      end
    end else begin
      want = deque_outcomes_q.pop_front();
      if (got !== want) begin
        errors++;
        if (errors <= 10) begin
          $display("%0t: result mismatch: expected data %0d status %0d occupancy %0d last %0b",
                   $realtime, want.data, want.status, want.occupancy, want.last);
          $display("%0t:                  got      data %0d status %0d occupancy %0d last %0b",
                   $realtime, got.data, got.status, got.occupancy, got.last);
        end
      end
    end
  endtask

  // Results first: a result never belongs to the request taken at the same edge
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  = '0;
      count_q = '0;
      deque_outcomes_q.delete();
      errors  = 0;
      pending_o    <= 0;
      mismatches_o <= 0;
    end else begin
      if (res_i.valid && res_i.ready) begin
        check_result();
      end
      if (req_i.valid && req_i.ready) begin
        run_deque_op(action_e'(req_i.action), req_i.operand);
      end
      pending_o    <= deque_outcomes_q.size();
      mismatches_o <= errors;
    end
  end

endmodule

// ===== tb/deque_with_value_delete_tb.sv =====
`timescale 1ns / 1ps

module deque_with_value_delete_tb;
  import dwvd_pkg::*;

  localparam int unsigned LIMIT        = 1_500_000;
  localparam int unsigned DRAIN_CYCLES = 300;

  typedef enum int {
    MODE_MIX,
    MODE_GROW,
    MODE_SHRINK
  } mode_e;

  logic        clk_i;
  logic        rst_ni;
  int unsigned mismatches;
  int unsigned pending;
  int unsigned cycle_count;
  int unsigned sent;
  bit          calm;

  logic signed [DATA_W-1:0] value_pool [8];

  dwvd_req_if req_if ();
  dwvd_res_if res_if ();

  deque_with_value_delete uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .res_o  (res_if)
  );

  deque_with_value_delete_chk dq_chk (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_i        (req_if),
    .res_i        (res_if),
    .mismatches_o (mismatches),
    .pending_o    (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Abort a hung run
  initial begin
    cycle_count = 0;
    while (cycle_count < LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("TEST FAILED");
    $finish;
  end

  // Result side: stall at random about 15 percent of the time, never during the calm stretch
  initial begin
    res_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      res_if.ready <= calm || ($urandom_range(99) >= 15);
    end
  end

  // Send one request, idling at random first, and hold it until taken
  task automatic issue(input action_e act, input logic signed [DATA_W-1:0] opnd);
    calm = (sent >= 150) && (sent < 260);
    if (!calm && ($urandom_range(99) < 15)) begin
      req_if.valid <= 1'b0;
      @(posedge clk_i);
      while ($urandom_range(99) < 15) @(posedge clk_i);
    end
    req_if.valid   <= 1'b1;
    req_if.action  <= act;
    req_if.operand <= opnd;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    sent++;
  endtask

  // Drop valid and hold off until every outstanding result has come back
  task automatic wait_drained();
    req_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  function automatic logic signed [DATA_W-1:0] pick_value();
    if ($urandom_range(99) < 60) return value_pool[$urandom_range(7)];
    return $urandom;
  endfunction

  // Read counts: mostly small, some zero, negative, beyond the fill level
  function automatic logic signed [DATA_W-1:0] pick_count();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 70) return $urandom_range(1, 10);
    if (r < 78) return 0;
    if (r < 86) return 32'h8000_0000 | $urandom;
    if (r < 94) return $urandom_range(11, 70);
    return 32'sh7fff_ffff;
  endfunction

  function automatic action_e pick_action(input mode_e mode);
    int unsigned r;
    r = $urandom_range(99);
    case (mode)
      MODE_GROW: begin
        if (r < 46) return ACT_PUSH_FRONT;
        if (r < 92) return ACT_PUSH_BACK;
        if (r < 96) return ACT_READ_FIRST;
        return ACT_READ_LAST;
      end
      MODE_SHRINK: begin
        if (r < 30) return ACT_POP_FRONT;
        if (r < 60) return ACT_POP_BACK;
        if (r < 72) return ACT_DELETE;
        if (r < 76) return ACT_PUSH_FRONT;
        if (r < 80) return ACT_PUSH_BACK;
        if (r < 90) return ACT_READ_FIRST;
        return ACT_READ_LAST;
      end
      default: begin
        if (r < 18) return ACT_PUSH_FRONT;
        if (r < 36) return ACT_PUSH_BACK;
        if (r < 48) return ACT_POP_FRONT;
        if (r < 60) return ACT_POP_BACK;
        if (r < 72) return ACT_DELETE;
        if (r < 75) return ACT_CLEAR;
        if (r < 87) return ACT_READ_FIRST;
        return ACT_READ_LAST;
      end
    endcase
  endfunction

  initial begin
    mode_e       plan [4];
    int unsigned plan_len [4];
    action_e     act;
    int          round;
    int          seg;
    int          k;

    plan     = '{MODE_MIX, MODE_GROW, MODE_MIX, MODE_SHRINK};
    plan_len = '{45, 72, 45, 60};
    value_pool[0] = 32'sh8000_0000;
    value_pool[1] = 32'sh7fff_ffff;
    value_pool[2] = 0;
    value_pool[3] = -1;
    for (k = 4; k < 8; k++) value_pool[k] = $urandom;

    sent = 0;
    calm = 1'b0;
    rst_ni         <= 1'b0;
    req_if.valid   <= 1'b0;
    req_if.action  <= ACT_PUSH_FRONT;
    req_if.operand <= '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Empty queue: pops, reads and delete all report or do nothing
    issue(ACT_POP_FRONT, 0);
    issue(ACT_POP_BACK, -1);
    issue(ACT_READ_FIRST, 5);
    issue(ACT_READ_LAST, -1);
    issue(ACT_DELETE, 0);
    // Extreme values at both ends
    issue(ACT_PUSH_BACK, 32'sh7fff_ffff);
    issue(ACT_PUSH_FRONT, 32'sh8000_0000);
    issue(ACT_PUSH_BACK, 0);
    issue(ACT_PUSH_FRONT, -1);
    issue(ACT_PUSH_BACK, 32'sh8000_0000);
    // Reads: zero and negative counts, over-long counts, last n
    issue(ACT_READ_FIRST, 0);
    issue(ACT_READ_FIRST, -3);
    issue(ACT_READ_FIRST, 100);
    issue(ACT_READ_LAST, 2);
    issue(ACT_READ_LAST, 32'sh8000_0000);
    issue(ACT_READ_LAST, 32'sh7fff_ffff);
    // Delete with two matches, then pops from both ends
    issue(ACT_DELETE, 32'sh8000_0000);
    issue(ACT_POP_FRONT, 0);
    issue(ACT_POP_BACK, 0);
    issue(ACT_READ_FIRST, 1);
    issue(ACT_CLEAR, 0);
    issue(ACT_READ_LAST, 3);
    issue(ACT_PUSH_FRONT, 32'sh5555_5555);
    issue(ACT_PUSH_BACK, 32'shAAAA_AAAA);
    issue(ACT_DELETE, 32'sh1234_5678);

    wait_drained();

    // Random phases: mixed, fill past full, mixed near full, drain
    for (round = 0; round < 2; round++) begin
      for (seg = 0; seg < 4; seg++) begin
        for (k = 0; k < plan_len[seg]; k++) begin
          act = pick_action(plan[seg]);
          case (act)
            ACT_READ_FIRST, ACT_READ_LAST: issue(act, pick_count());
            ACT_PUSH_FRONT, ACT_PUSH_BACK, ACT_DELETE: issue(act, pick_value());
            default: issue(act, $urandom);
          endcase
        end
      end
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
